// ===== rtl/dmd_pkg.sv =====
package dmd_pkg;

	localparam int MaxDims = 16;
	localparam int MaxCentres = 16;
	localparam int DimW = 4;
	localparam int CenW = 4;
	localparam int AddrW = 8;
	localparam int DistW = 36;
	localparam logic [DistW-1:0] DistMax = '1;

	localparam logic [1:0] FUNC_CENTRE = 2'd0;
	localparam logic [1:0] FUNC_SPREAD = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;
	localparam logic [1:0] FUNC_IGNORE = 2'd3;

	localparam logic [1:0] REG_DIMS = 2'd0;
	localparam logic [1:0] REG_CENTRES = 2'd1;
	localparam logic [1:0] REG_MASK = 2'd2;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// command from front to back
	typedef struct packed {
		logic [1:0] func;
		logic [CenW-1:0] centre_index;
		logic [DimW-1:0] dim_index;
		logic [15:0] value;
		logic last_element;
	} cmd_t;

	typedef struct packed {
		logic [CenW-1:0] result_centre;
		logic [DistW-1:0] distance;
		logic zero_spread;
		logic last_result;
	} res_t;

endpackage

// ===== rtl/dmd_front.sv =====
module dmd_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] func,
	input logic [3:0] centre_index,
	input logic [3:0] dim_index,
	input logic signed [15:0] value,
	input logic last_element,
	output logic cmd_valid,
	input logic cmd_take,
	output dmd_pkg::cmd_t cmd
);

	// two-entry queue, func 3 is dropped at the door
	dmd_pkg::cmd_t mem_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic wr;

	assign full = (cnt_q == 2'd2);
	assign wr = push && !full && (func != dmd_pkg::FUNC_IGNORE);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_q] <= '{func, centre_index, dim_index, value, last_element};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wr_q <= !wr_q;
			if (cmd_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, cmd_take};
		end
	end

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid) else $error("take from empty queue");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count overflow");

endmodule

// ===== rtl/dmd_div.sv =====
module dmd_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [24:0] num,
	input logic [15:0] den,
	output logic done,
	output logic [24:0] quo
);

	// restoring divider, one quotient bit a cycle
	logic [24:0] n_q;
	logic [16:0] r_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [17:0] trial;
	logic [16:0] r_sh;

	assign r_sh = {r_q[15:0], n_q[24]};
	assign trial = {1'b0, r_sh} - {2'b0, den};
	assign quo = n_q;

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= trial[17] ? r_sh : trial[16:0];
			n_q <= {n_q[23:0], !trial[17]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd24;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("done while busy");

endmodule

// ===== rtl/dmd_back.sv =====
module dmd_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_take,
	input dmd_pkg::cmd_t cmd,
	input logic [4:0] dims_used,
	input logic [4:0] centres_used,
	input logic [15:0] dim_mask,
	output logic empty,
	input logic pop,
	output dmd_pkg::res_t res
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD = 7'b0000010,
		S_DAT = 7'b0000100,
		S_DIV = 7'b0001000,
		S_SQ = 7'b0010000,
		S_ACC = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t st_q;
	logic [15:0] ctab [256];
	logic [15:0] stab [256];
	logic [15:0] qvec_q [16];
	logic [15:0] cm_q, sp_q;
	logic [3:0] c_q, j_q, nd_q, nc_q;
	logic [35:0] acc_q;
	logic zf_q, neg_q;
	logic [15:0] qs_q;
	logic [31:0] sq_q;
	logic [7:0] addr;
	logic div_start, div_done;
	logic [24:0] div_quo;
	logic signed [16:0] diff;
	logic [16:0] mag;
	logic [15:0] smag;
	logic [36:0] sum;
	logic res_full_q;
	logic skip;

	assign addr = {c_q, j_q};
	assign diff = {qvec_q[j_q][15], qvec_q[j_q]} - {cm_q[15], cm_q};
	assign mag = diff[16] ? 17'(-diff) : 17'(diff);
	assign smag = sp_q[15] ? 16'(-sp_q) : sp_q;
	assign skip = !dim_mask[j_q];
	assign sum = {1'b0, acc_q} + {5'b0, sq_q};
	assign empty = !res_full_q;
	// every command leaves the queue when idle; a final query element then starts the sweep
	assign cmd_take = (st_q == S_IDLE) && cmd_valid;
	assign div_start = (st_q == S_DAT) && !skip && smag != 16'd0;

	dmd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({mag, 8'd0}), .den(smag), .done(div_done), .quo(div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd_valid && st_q == S_IDLE) begin
			if (cmd.func == dmd_pkg::FUNC_CENTRE) ctab[{cmd.centre_index, cmd.dim_index}] <= cmd.value;
			if (cmd.func == dmd_pkg::FUNC_SPREAD) stab[{cmd.centre_index, cmd.dim_index}] <= cmd.value;
			if (cmd.func == dmd_pkg::FUNC_QUERY) qvec_q[cmd.dim_index] <= cmd.value;
		end
		cm_q <= ctab[addr];
		sp_q <= stab[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			res_full_q <= 1'b0;
			c_q <= '0;
			j_q <= '0;
		end else begin
			if (pop && res_full_q) res_full_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (cmd_valid && cmd.func == dmd_pkg::FUNC_QUERY && cmd.last_element) begin
						nd_q <= (dims_used == 5'd0) ? 4'd0 :
							(dims_used > 5'd16) ? 4'd15 : 4'(dims_used - 5'd1);
						nc_q <= (centres_used == 5'd0) ? 4'd0 :
							(centres_used > 5'd16) ? 4'd15 : 4'(centres_used - 5'd1);
						c_q <= '0;
						j_q <= '0;
						acc_q <= '0;
						zf_q <= 1'b0;
						st_q <= S_RD;
					end
				end
				S_RD: st_q <= S_DAT;
				S_DAT: begin
					neg_q <= diff[16];
					if (skip) st_q <= S_ACC;
					else if (smag == 16'd0) begin
						zf_q <= 1'b1;
						st_q <= S_ACC;
					end else st_q <= S_DIV;
					sq_q <= '0;
				end
				S_DIV: if (div_done) begin
					if (neg_q) qs_q <= (div_quo > 25'd32768) ? 16'h8000 : div_quo[15:0];
					else qs_q <= (div_quo > 25'd32767) ? 16'h7fff : div_quo[15:0];
					st_q <= S_SQ;
				end
				S_SQ: begin
					// magnitude squared, 16x16
					sq_q <= ({16'b0, qs_q} * {16'b0, qs_q});
					st_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= sum[36] ? dmd_pkg::DistMax : sum[35:0];
					if (j_q == nd_q) st_q <= S_OUT;
					else begin
						j_q <= j_q + 4'd1;
						st_q <= S_RD;
					end
				end
				S_OUT: if (!res_full_q || pop) begin
					res <= '{c_q, zf_q ? dmd_pkg::DistMax : acc_q, zf_q, c_q == nc_q};
					res_full_q <= 1'b1;
					acc_q <= '0;
					zf_q <= 1'b0;
					j_q <= '0;
					if (c_q == nc_q) st_q <= S_IDLE;
					else begin
						c_q <= c_q + 4'd1;
						st_q <= S_RD;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> st_q == S_IDLE) else $error("take while busy");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state not one-hot");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OUT && (!res_full_q || pop) && c_q == nc_q) |=> st_q == S_IDLE)
		else $error("no return to idle");

endmodule

// ===== rtl/diagonal_mahalanobis_distance.sv =====
// loads and non-final query elements pass through a two-entry queue; push is refused while full
// final query element: each centre sweeps its dimensions, an enabled dimension waiting
// on the bit-serial divider; masked or zero-spread dimensions skip the divider
// results held in one output register; the next centre computes meanwhile
// arst_n clears control; tables and query vector undefined until written
module diagonal_mahalanobis_distance (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] func,
	input logic [3:0] centre_index,
	input logic [3:0] dim_index,
	input logic signed [15:0] value,
	input logic last_element,
	output logic empty,
	input logic pop,
	output logic [3:0] result_centre,
	output logic [35:0] distance,
	output logic zero_spread,
	output logic last_result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	logic [4:0] dims_q, cent_q;
	logic [15:0] mask_q;
	logic cmd_valid, cmd_take;
	dmd_pkg::cmd_t cmd;
	dmd_pkg::res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 5'd16;
			cent_q <= 5'd16;
			mask_q <= 16'hffff;
		end else if (cfg_valid) begin
			case (cfg_index)
				dmd_pkg::REG_DIMS: dims_q <= cfg_data[4:0];
				dmd_pkg::REG_CENTRES: cent_q <= cfg_data[4:0];
				dmd_pkg::REG_MASK: mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	dmd_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.centre_index(centre_index), .dim_index(dim_index), .value(value),
		.last_element(last_element), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	dmd_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
		.dims_used(dims_q), .centres_used(cent_q), .dim_mask(mask_q),
		.empty(empty), .pop(pop), .res(res)
	);

	assign result_centre = res.result_centre;
	assign distance = res.distance;
	assign zero_spread = res.zero_spread;
	assign last_result = res.last_result;

endmodule
